@@ hw/rtl/bfc_pkg.sv @@
// Shared types, constants and helper functions for the block Fletcher-16 checksum unit.
// No dependencies; used by bfc_sum_core and block_fletcher16_checksum_unit.
`timescale 1ns / 1ps

package bfc_pkg;

   localparam int BYTE_W            = 8;
   localparam int SUM_W             = 16;
   localparam int ADDR_W            = 16;
   localparam int CHUNK_LEN_DEFAULT = 20;

   localparam logic [SUM_W-1:0] SUM_INIT = 16'h00FF;

   // One request as it travels from the input register to the sum core.
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
      logic [ADDR_W-1:0] block_address;
   } item_type;

   // Adds the high byte of a sum to its low byte.
   function automatic logic [SUM_W-1:0] fold8(input logic [SUM_W-1:0] v);
      return {8'h00, v[7:0]} + {8'h00, v[15:8]};
   endfunction

endpackage

@@ hw/rtl/bfc_sum_core.sv @@
// Running Fletcher-16 sums, chunk counter and end-of-block checksum logic.
// Depends on bfc_pkg for the item type, widths and the fold function.
`timescale 1ns / 1ps

module bfc_sum_core #(
   parameter int CHUNK_LEN = bfc_pkg::CHUNK_LEN_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  bfc_pkg::item_type            item,
   output logic [bfc_pkg::SUM_W-1:0]    checksum
);

   localparam int POS_W = $clog2(CHUNK_LEN + 1);

   logic [bfc_pkg::SUM_W-1:0] low_sum_ff, low_sum_in;
   logic [bfc_pkg::SUM_W-1:0] high_sum_ff, high_sum_in;
   logic [POS_W-1:0]          chunk_pos_ff, chunk_pos_in;

   logic [bfc_pkg::SUM_W-1:0] low_add, high_add;
   logic [bfc_pkg::SUM_W-1:0] low_chunk, high_chunk;
   logic [bfc_pkg::SUM_W-1:0] low_final, high_final;
   logic [POS_W-1:0]          pos_inc;
   logic                      chunk_end;

   always_comb begin
      low_add   = low_sum_ff + {8'h00, item.data_byte};
      high_add  = high_sum_ff + low_add;
      pos_inc   = chunk_pos_ff + POS_W'(1);
      chunk_end = (pos_inc >= POS_W'(CHUNK_LEN)) || item.last_byte;

      // A last byte that also closes a chunk still gets only one chunk fold.
      low_chunk  = chunk_end ? bfc_pkg::fold8(low_add) : low_add;
      high_chunk = chunk_end ? bfc_pkg::fold8(high_add) : high_add;

      low_final  = bfc_pkg::fold8(low_chunk);
      high_final = bfc_pkg::fold8(high_chunk);

      // Packed as (high << 8) | low truncated to 16 bits, then XORed with the address.
      checksum = {high_final[7:0] | low_final[15:8], low_final[7:0]} ^ item.block_address;

      low_sum_in   = low_sum_ff;
      high_sum_in  = high_sum_ff;
      chunk_pos_in = chunk_pos_ff;
      if (advance) begin
         if (item.last_byte) begin
            low_sum_in   = bfc_pkg::SUM_INIT;
            high_sum_in  = bfc_pkg::SUM_INIT;
            chunk_pos_in = '0;
         end else begin
            low_sum_in   = low_chunk;
            high_sum_in  = high_chunk;
            chunk_pos_in = chunk_end ? '0 : pos_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_sum_ff   <= bfc_pkg::SUM_INIT;
         high_sum_ff  <= bfc_pkg::SUM_INIT;
         chunk_pos_ff <= '0;
      end else begin
         low_sum_ff   <= low_sum_in;
         high_sum_ff  <= high_sum_in;
         chunk_pos_ff <= chunk_pos_in;
      end
   end

   // The chunk counter is cleared before it can reach the chunk length.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      chunk_pos_ff < POS_W'(CHUNK_LEN))
      else $error("chunk position reached the chunk length");

   // Closing a block returns the sums and counter to their start values.
   a_block_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && item.last_byte) |=>
         (low_sum_ff == bfc_pkg::SUM_INIT) && (high_sum_ff == bfc_pkg::SUM_INIT) &&
         (chunk_pos_ff == '0))
      else $error("sums not restarted after the last byte of a block");

endmodule

@@ hw/rtl/block_fletcher16_checksum_unit.sv @@
// Top level of the block Fletcher-16 checksum unit: input register, result register, handshake.
// Depends on bfc_pkg and bfc_sum_core.
`timescale 1ns / 1ps

// Usage.
// Each request on the req_ channel carries one payload byte of a storage block. The request
// with req_last_byte high closes the block, and its req_block_address is XORed into the
// checksum; the address of other requests is ignored. One response per block appears on the
// rsp_ channel, carrying the folded Fletcher-16 value XOR the block address.
// A request is registered in the input register when it is accepted, and the sums are updated
// from that register when it moves on; a last byte moves on only when the result register is
// free, and its response is then held in that register until taken. The combinational add,
// add and fold of the running sums sets the throughput at one byte per cycle, sustained while
// the response side keeps up.
// Synchronous reset empties both registers and sets both sums to 0xFF and the chunk count to
// zero. When the receiver stalls, the response waits in its register; bytes that do not close
// a block keep flowing, and only a second last byte waits, in the input register, until the
// pending response is taken. req_ready then drops until that stage moves on.

module block_fletcher16_checksum_unit #(
   parameter int CHUNK_LEN = bfc_pkg::CHUNK_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bfc_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                          req_last_byte,
   input  logic [bfc_pkg::ADDR_W-1:0]    req_block_address,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bfc_pkg::SUM_W-1:0]     rsp_block_checksum
);

   // Input register stage.
   logic              s1_valid_ff, s1_valid_in;
   bfc_pkg::item_type s1_item_ff, s1_item_in;

   // Result register stage.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [bfc_pkg::SUM_W-1:0] rsp_checksum_ff, rsp_checksum_in;

   logic                      out_free;
   logic                      s1_fire;
   logic                      req_fire;
   logic [bfc_pkg::SUM_W-1:0] core_checksum;

   // The result register can be loaded when it is empty or is being emptied this cycle.
   // Only a last byte needs that space; other bytes just update the sums.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_item_ff.last_byte || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_item_in = s1_item_ff;
      if (req_fire) begin
         s1_item_in.data_byte     = req_data_byte;
         s1_item_in.last_byte     = req_last_byte;
         s1_item_in.block_address = req_block_address;
      end

      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      rsp_checksum_in = rsp_checksum_ff;
      if (s1_fire && s1_item_ff.last_byte) begin
         rsp_valid_in    = 1'b1;
         rsp_checksum_in = core_checksum;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   bfc_sum_core #(
      .CHUNK_LEN (CHUNK_LEN)
   ) u_sum_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (s1_fire),
      .item     (s1_item_ff),
      .checksum (core_checksum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff      <= s1_item_in;
      rsp_checksum_ff <= rsp_checksum_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_block_checksum = rsp_checksum_ff;

   // A last byte that leaves the input stage always produces a response.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_item_ff.last_byte) |=> rsp_valid_ff)
      else $error("last byte processed without a response");

   // A byte that does not close a block never creates a response.
   a_mid_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_item_ff.last_byte && out_free) |=> !rsp_valid_ff)
      else $error("response created by a byte that does not close a block");

   // An empty input stage always takes a new request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("input stage empty but request not accepted");

   // A last byte waiting in the input stage holds while the response is stalled.
   a_last_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_item_ff.last_byte && rsp_valid_ff && !rsp_ready) |=>
         (s1_valid_ff && $stable(s1_item_ff)))
      else $error("stalled last byte lost from the input stage");

endmodule
